FILE: hw/rtl/mfc_pkg.sv
// shared types and constants of the multichannel fir convolver
// no dependencies; used by mfc_mac and multichannel_fir_convolver
`default_nettype none

package mfc_pkg;

    localparam int COEF_W   = 16;
    localparam int SUM_W    = 40;
    localparam int CHAN_W   = 3;
    localparam int INDEX_W  = 8;
    localparam int TCOUNT_W = 9;
    localparam int OUT_W    = ((CHAN_W + SUM_W + 7) / 8) * 8;

    localparam logic [TCOUNT_W-1:0] TAP_COUNT_RESET = 9'd256;

    // configuration register indexes
    localparam logic [7:0] CFG_TAP_COUNT   = 8'd0;
    localparam logic [7:0] CFG_SHARED_TAPS = 8'd1;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic data_valid;
    } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mfc_mac.sv
// multiply-accumulate pipeline: registered product, then 40-bit wrapping sum
// depends on mfc_pkg
`default_nettype none

module mfc_mac #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire mfc_pkg::mac_ctrl_t                ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0]     hist_data,
    input  wire logic signed [mfc_pkg::COEF_W-1:0] coef_data,
    output logic                                   busy,
    output logic signed [mfc_pkg::SUM_W-1:0]       acc
);

    localparam int PROD_W = SAMPLE_BITS + mfc_pkg::COEF_W;

    logic signed [PROD_W-1:0]         prod_reg;
    logic                             prod_valid_reg;
    logic                             prod_valid_next;
    logic signed [mfc_pkg::SUM_W-1:0] acc_reg;
    logic signed [mfc_pkg::SUM_W-1:0] acc_next;

    always_comb
    begin
        prod_valid_next = ctrl.data_valid & ~ctrl.clear;
        acc_next        = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + mfc_pkg::SUM_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= hist_data * coef_data;
        acc_reg  <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
        end
    end

    assign busy = prod_valid_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/multichannel_fir_convolver.sv
// top level of the multichannel direct-form fir convolver
// depends on mfc_pkg and mfc_mac
//
// A sample is convolved over used taps, where used is the smaller of the
// effective tap count and the samples seen on that channel since its
// restart: one tap per cycle, set by the single read port of the
// coefficient and history memories feeding one multiplier. Each tap passes
// the memory read registers, the product register and the accumulator; the
// drain state waits for that pipeline to empty, and then the result register
// is loaded. The next transaction is accepted once the result register is
// loaded. The result register lets the next transaction be accepted while a
// result waits. Both memories hold undefined data after reset and need no
// clearing.
`default_nettype none

module multichannel_fir_convolver #(
    parameter int CHANNELS    = 8,
    parameter int TAPS        = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // configuration write channel
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire [7:0]                             cfg_index,
    input  wire [mfc_pkg::TCOUNT_W-1:0]           cfg_data,
    // input stream
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // channel, restart, sample, tap_index, tap_value, zero fill
    input  wire [((35 + SAMPLE_BITS) / 8) * 8-1:0] s_axis_tdata,
    // cmd
    input  wire                                   s_axis_tuser,
    // output stream
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // out_channel, filtered, zero fill
    output logic [mfc_pkg::OUT_W-1:0]             m_axis_tdata
);

    localparam int TAP_W  = $clog2(TAPS);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH  = CHANNELS * TAPS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int LIM_W  = (CNT_W > mfc_pkg::TCOUNT_W) ? CNT_W : mfc_pkg::TCOUNT_W;
    localparam int SMP_LO = mfc_pkg::CHAN_W + 1;
    localparam int IDX_LO = SMP_LO + SAMPLE_BITS;
    localparam int VAL_LO = IDX_LO + mfc_pkg::INDEX_W;

    // input fields
    logic [mfc_pkg::CHAN_W-1:0]         in_channel;
    logic                               in_restart;
    logic [SAMPLE_BITS-1:0]             in_sample;
    logic [mfc_pkg::INDEX_W-1:0]        in_tap_index;
    logic [mfc_pkg::COEF_W-1:0]         in_tap_value;
    logic                               in_cmd;

    assign in_channel   = s_axis_tdata[mfc_pkg::CHAN_W-1:0];
    assign in_restart   = s_axis_tdata[mfc_pkg::CHAN_W];
    assign in_sample    = s_axis_tdata[SMP_LO +: SAMPLE_BITS];
    assign in_tap_index = s_axis_tdata[IDX_LO +: mfc_pkg::INDEX_W];
    assign in_tap_value = s_axis_tdata[VAL_LO +: mfc_pkg::COEF_W];
    assign in_cmd       = s_axis_tuser;

    // configuration
    logic [mfc_pkg::TCOUNT_W-1:0] tap_count_reg;
    logic                         shared_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= mfc_pkg::TAP_COUNT_RESET;
            shared_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == mfc_pkg::CFG_TAP_COUNT)
            begin
                tap_count_reg <= cfg_data;
            end
            else if (cfg_index == mfc_pkg::CFG_SHARED_TAPS)
            begin
                shared_reg <= cfg_data[0];
            end
        end
    end

    // control registers
    mfc_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [TAP_W-1:0]  hpos_reg, hpos_next;
    logic [ADDR_W-1:0] hist_base_reg, hist_base_next;
    logic [ADDR_W-1:0] coef_base_reg, coef_base_next;
    logic [mfc_pkg::CHAN_W-1:0] chan_reg, chan_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [mfc_pkg::CHAN_W-1:0] out_chan_reg;
    logic [mfc_pkg::SUM_W-1:0]  out_sum_reg;

    // per-channel history pointers
    logic [TAP_W-1:0] wp_reg   [CHANNELS];
    logic [CNT_W-1:0] seen_reg [CHANNELS];

    // memories
    logic [mfc_pkg::COEF_W-1:0] coef_mem [DEPTH];
    logic [SAMPLE_BITS-1:0]     hist_mem [DEPTH];
    logic [mfc_pkg::COEF_W-1:0] coef_rdata_reg;
    logic [SAMPLE_BITS-1:0]     hist_rdata_reg;

    logic              in_go;
    logic              chan_ok;
    logic              load_go;
    logic              sample_go;
    logic [CH_W-1:0]   ch_sel;
    logic [CH_W-1:0]   bank_sel;
    logic [TAP_W-1:0]  pos_new;
    logic [CNT_W-1:0]  seen_new;
    logic [LIM_W-1:0]  taps_eff;
    logic [LIM_W-1:0]  seen_ext;
    logic [ADDR_W-1:0] coef_waddr;
    logic [ADDR_W-1:0] hist_waddr;
    logic [ADDR_W-1:0] coef_raddr;
    logic [ADDR_W-1:0] hist_raddr;
    logic              issue;
    logic              load_out;

    mfc_pkg::mac_ctrl_t               mac_ctrl;
    logic                             mac_busy;
    logic signed [mfc_pkg::SUM_W-1:0] mac_acc;

    assign s_axis_tready = (state_reg == mfc_pkg::ST_IDLE);
    assign in_go         = s_axis_tvalid & s_axis_tready;
    assign chan_ok       = (32'(in_channel) < CHANNELS);
    assign load_go       = in_go & (in_cmd == mfc_pkg::CMD_LOAD) & chan_ok &
                           (32'(in_tap_index) < TAPS);
    assign sample_go     = in_go & (in_cmd == mfc_pkg::CMD_SAMPLE) & chan_ok;
    assign ch_sel        = CH_W'(in_channel);
    assign bank_sel      = shared_reg ? '0 : ch_sel;

    always_comb
    begin
        if (in_restart)
        begin
            pos_new  = '0;
            seen_new = CNT_W'(1);
        end
        else
        begin
            pos_new  = wp_reg[ch_sel];
            seen_new = (32'(seen_reg[ch_sel]) < TAPS) ? seen_reg[ch_sel] + CNT_W'(1)
                                                      : seen_reg[ch_sel];
        end
    end

    assign taps_eff = (LIM_W'(tap_count_reg) > LIM_W'(TAPS)) ? LIM_W'(TAPS)
                                                             : LIM_W'(tap_count_reg);
    assign seen_ext = LIM_W'(seen_new);

    assign coef_waddr = ADDR_W'(32'(ch_sel) * TAPS + 32'(in_tap_index));
    assign hist_waddr = ADDR_W'(32'(ch_sel) * TAPS + 32'(pos_new));
    assign coef_raddr = coef_base_reg + ADDR_W'(k_reg[TAP_W-1:0]);
    assign hist_raddr = hist_base_reg + ADDR_W'(hpos_reg);

    assign issue    = (state_reg == mfc_pkg::ST_MAC) & (k_reg < used_reg);
    assign load_out = (state_reg == mfc_pkg::ST_OUT) & (~out_valid_reg | m_axis_tready);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        used_next      = used_reg;
        hpos_next      = hpos_reg;
        hist_base_next = hist_base_reg;
        coef_base_next = coef_base_reg;
        chan_next      = chan_reg;
        rd_valid_next  = issue;
        out_valid_next = out_valid_reg & ~m_axis_tready;

        unique case (state_reg)
            mfc_pkg::ST_IDLE:
            begin
                if (sample_go)
                begin
                    k_next         = '0;
                    used_next      = (seen_ext < taps_eff) ? seen_new : CNT_W'(taps_eff);
                    hpos_next      = pos_new;
                    hist_base_next = ADDR_W'(32'(ch_sel) * TAPS);
                    coef_base_next = ADDR_W'(32'(bank_sel) * TAPS);
                    chan_next      = in_channel;
                    state_next     = mfc_pkg::ST_MAC;
                end
            end
            mfc_pkg::ST_MAC:
            begin
                if (issue)
                begin
                    k_next    = k_reg + CNT_W'(1);
                    hpos_next = (hpos_reg == '0) ? TAP_W'(TAPS - 1) : hpos_reg - TAP_W'(1);
                end
                else
                begin
                    state_next = mfc_pkg::ST_DRAIN;
                end
            end
            mfc_pkg::ST_DRAIN:
            begin
                if (!rd_valid_reg && !mac_busy)
                begin
                    state_next = mfc_pkg::ST_OUT;
                end
            end
            mfc_pkg::ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = mfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mfc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfc_pkg::ST_IDLE;
            k_reg         <= '0;
            used_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i]   <= '0;
                seen_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            used_reg      <= used_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            if (sample_go)
            begin
                wp_reg[ch_sel]   <= (32'(pos_new) == TAPS - 1) ? '0 : pos_new + TAP_W'(1);
                seen_reg[ch_sel] <= seen_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hpos_reg      <= hpos_next;
        hist_base_reg <= hist_base_next;
        coef_base_reg <= coef_base_next;
        chan_reg      <= chan_next;
        if (load_out)
        begin
            out_chan_reg <= chan_reg;
            out_sum_reg  <= mac_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            coef_mem[coef_waddr] <= in_tap_value;
        end
        coef_rdata_reg <= coef_mem[coef_raddr];
    end

    // the sample written on acceptance is read back no earlier than the next cycle
    always_ff @(posedge clk)
    begin
        if (sample_go)
        begin
            hist_mem[hist_waddr] <= in_sample;
        end
        hist_rdata_reg <= hist_mem[hist_raddr];
    end

    assign mac_ctrl.clear      = sample_go;
    assign mac_ctrl.data_valid = rd_valid_reg;

    mfc_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .hist_data (hist_rdata_reg),
        .coef_data (coef_rdata_reg),
        .busy      (mac_busy),
        .acc       (mac_acc)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(mfc_pkg::OUT_W - mfc_pkg::CHAN_W - mfc_pkg::SUM_W){1'b0}},
                            out_sum_reg, out_chan_reg};

endmodule

`default_nettype wire
